// ===== rtl/event_timer_register_block_assert.svh =====
// Assertion macros shared by the event timer register block RTL.
`ifndef EVENT_TIMER_REGISTER_BLOCK_ASSERT_SVH
`define EVENT_TIMER_REGISTER_BLOCK_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ETR_ASSERT_NOW(label, clk_sig, rst_sig, cond, check) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond) |-> (check)) \
    else $error("event timer assertion failed");

// Next-cycle implication, checked outside reset.
`define ETR_ASSERT_NEXT(label, clk_sig, rst_sig, cond, check) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond) |=> (check)) \
    else $error("event timer assertion failed");

`endif

// ===== rtl/etr_pkg.sv =====
// Package with types and constants of the event timer register block.
`default_nettype none
package etr_pkg;

  localparam int unsigned NUM_TIMERS_DEF = 3;
  localparam int unsigned FIRED_W        = 3;
  localparam int unsigned PERIOD_W       = 27;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 27'd10000000;

  localparam logic [9:0] OFF_CAPS    = 10'h000;
  localparam logic [9:0] OFF_CONFIG  = 10'h010;
  localparam logic [9:0] OFF_COUNTER = 10'h0F0;
  localparam int unsigned OFF_TIMER_BASE = 'h100;
  localparam int unsigned OFF_CMP_BASE   = 'h108;
  localparam int unsigned TIMER_STRIDE   = 'h20;

  // Bit positions inside the register layouts.
  localparam int unsigned GCFG_ENABLE_BIT   = 0;
  localparam int unsigned TCFG_INTEN_BIT    = 2;
  localparam int unsigned TCFG_PERIODIC_BIT = 3;
  localparam int unsigned TCFG_ROUTE_LSB    = 9;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } command_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [9:0]  register_offset;
    logic [63:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [63:0]        read_data;
    logic [FIRED_W-1:0] timers_fired;
  } out_word_t;

  // Strobes from the decode logic to one timer.
  typedef struct packed {
    logic cfg_we;
    logic cmp_we;
    logic tick;
  } timer_ctl_t;

  // State that one timer reports back.
  typedef struct packed {
    logic        inten;
    logic        periodic;
    logic [4:0]  route;
    logic [63:0] cmp;
    logic        fired;
  } timer_stat_t;

endpackage
`default_nettype wire

// ===== rtl/etr_timer.sv =====
// One comparator timer: settings, comparator, repeat interval and write phase.
`default_nettype none
module etr_timer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire etr_pkg::timer_ctl_t ctl,
  input  wire logic [63:0]        wdata,
  input  wire logic [63:0]        count_next,
  output etr_pkg::timer_stat_t    stat
);
  import etr_pkg::*;

  logic        inten;
  logic        periodic;
  logic [4:0]  route;
  logic [63:0] cmp;
  logic [63:0] interval;
  logic        pending;
  logic        fire;
  logic [63:0] cmp_advanced;

  assign fire         = ctl.tick && inten && (count_next == cmp);
  assign cmp_advanced = cmp + interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      inten    <= 1'b0;
      periodic <= 1'b0;
      route    <= '0;
      cmp      <= '1;
      interval <= '0;
      pending  <= 1'b0;
    end else begin
      if (ctl.cfg_we) begin
        inten    <= wdata[TCFG_INTEN_BIT];
        periodic <= wdata[TCFG_PERIODIC_BIT];
        route    <= wdata[TCFG_ROUTE_LSB +: 5];
        pending  <= 1'b0;
      end
      if (ctl.cmp_we) begin
        // In periodic mode the second word of a pair sets the interval.
        if (periodic && pending) begin
          interval <= wdata;
          pending  <= 1'b0;
        end else begin
          cmp     <= wdata;
          pending <= periodic;
        end
      end
      if (fire && periodic) begin
        cmp <= cmp_advanced;
      end
    end
  end

  assign stat.inten    = inten;
  assign stat.periodic = periodic;
  assign stat.route    = route;
  assign stat.cmp      = cmp;
  assign stat.fired    = fire;

endmodule
`default_nettype wire

// ===== rtl/event_timer_register_block.sv =====
// Top level: item register, main counter, register decode and result register.
//
//   channel   direction  handshake                   word
//   item      in         item_valid / item_ready     etr_pkg::in_word_t
//   result    out        result_valid / result_ready etr_pkg::out_word_t
//   cfg       in         cfg_valid / cfg_ready       cfg_data (tick period)
//
// One item per clock sustained while result_ready is high; a word is processed
// once it is in the item register and the result register is free, and its
// result then goes into the result register. The timer compare (one 64-bit add
// and compare per timer) sets the path. Reset is synchronous; cfg_ready is
// always high. A stalled result holds the result register and lets one more
// item wait in the item register before item_ready drops.
`default_nettype none
module event_timer_register_block #(
  parameter int unsigned NUM_TIMERS = etr_pkg::NUM_TIMERS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_ready,
  input  wire etr_pkg::in_word_t             item,
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output etr_pkg::out_word_t                 result,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [etr_pkg::PERIOD_W-1:0]  cfg_data
);
  import etr_pkg::*;

  in_word_t             in_q;
  logic                 in_held;
  logic                 advance;
  logic [PERIOD_W-1:0]  period;
  logic [63:0]          main_count;
  logic [63:0]          count_next;
  logic                 count_enable;
  logic                 is_read;
  logic                 is_write;
  logic                 tick_go;
  logic [63:0]          read_data_next;
  logic [63:0]          timer_rd [NUM_TIMERS];
  logic [FIRED_W-1:0]   fired_next;
  timer_ctl_t           ctl [NUM_TIMERS];
  timer_stat_t          stat [NUM_TIMERS];
  out_word_t            result_next;

  assign advance    = in_held && (!result_valid || result_ready);
  assign item_ready = !in_held || advance;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (item_ready) begin
      in_held <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      in_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
    end else if (cfg_valid) begin
      period <= cfg_data;
    end
  end

  always_comb begin
    is_read  = 1'b0;
    is_write = 1'b0;
    tick_go  = 1'b0;
    case (in_q.command)
      CMD_READ:  is_read  = advance;
      CMD_WRITE: is_write = advance;
      CMD_TICK:  tick_go  = advance && count_enable;
      default: ;
    endcase
  end

  assign count_next = main_count + 64'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_count   <= '0;
      count_enable <= 1'b0;
    end else begin
      if (tick_go) begin
        main_count <= count_next;
      end else if (is_write && in_q.register_offset == OFF_COUNTER) begin
        main_count <= in_q.write_data;
      end
      if (is_write && in_q.register_offset == OFF_CONFIG) begin
        count_enable <= in_q.write_data[GCFG_ENABLE_BIT];
      end
    end
  end

  for (genvar n = 0; n < NUM_TIMERS; n++) begin : g_timer
    localparam logic [9:0] CfgOff = 10'(OFF_TIMER_BASE + n * TIMER_STRIDE);
    localparam logic [9:0] CmpOff = 10'(OFF_CMP_BASE + n * TIMER_STRIDE);

    assign ctl[n].cfg_we = is_write && in_q.register_offset == CfgOff;
    assign ctl[n].cmp_we = is_write && in_q.register_offset == CmpOff;
    assign ctl[n].tick   = tick_go;

    etr_timer u_timer (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl[n]),
      .wdata      (in_q.write_data),
      .count_next (count_next),
      .stat       (stat[n])
    );

    always_comb begin
      if (in_q.register_offset == CfgOff) begin
        timer_rd[n] = {50'd0, stat[n].route, 4'd0, 1'b1, stat[n].periodic,
                       stat[n].inten, 2'd0};
      end else if (in_q.register_offset == CmpOff) begin
        timer_rd[n] = stat[n].cmp;
      end else begin
        timer_rd[n] = '0;
      end
    end
  end

  always_comb begin
    read_data_next = '0;
    fired_next     = '0;
    if (is_read) begin
      if (in_q.register_offset == OFF_CAPS) begin
        read_data_next = {5'd0, period, 19'd0, 5'(NUM_TIMERS - 1), 8'd0};
      end else if (in_q.register_offset == OFF_CONFIG) begin
        read_data_next = {63'd0, count_enable};
      end else if (in_q.register_offset == OFF_COUNTER) begin
        read_data_next = main_count;
      end else begin
        // Timer offsets are distinct, so at most one term is nonzero.
        for (int n = 0; n < NUM_TIMERS; n++) begin
          read_data_next = read_data_next | timer_rd[n];
        end
      end
    end
    for (int n = 0; n < NUM_TIMERS; n++) begin
      fired_next[n] = stat[n].fired;
    end
  end

  assign result_next.read_data    = read_data_next;
  assign result_next.timers_fired = fired_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

`include "event_timer_register_block_assert.svh"

  `ETR_ASSERT_NOW(a_no_overwrite, clk, rst, result_valid && !result_ready, !advance)
  `ETR_ASSERT_NEXT(a_halted_tick, clk, rst,
                   advance && in_q.command == CMD_TICK && !count_enable,
                   $stable(main_count) && result.timers_fired == '0)
  `ETR_ASSERT_NEXT(a_quiet_read_data, clk, rst,
                   advance && in_q.command != CMD_READ, result.read_data == '0)
  `ETR_ASSERT_NOW(a_unused_fired, clk, rst, result_valid,
                  (result.timers_fired >> NUM_TIMERS) == '0)

endmodule
`default_nettype wire

// ===== test/event_timer_register_block_tb.sv =====
// Self-checking testbench for the event timer register block.
`default_nettype none
module event_timer_register_block_tb;
  import etr_pkg::*;

  localparam int NUM_T        = NUM_TIMERS_DEF;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 200;
  localparam int HOLD_OFF     = 300;
  localparam int DRAIN_CYCLES = 6;
  localparam int STALL_LIMIT  = 2000;
  localparam int TCFG_PERCAP_BIT = 4;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN = 27'd1;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 27'd100000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  in_word_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  out_word_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [PERIOD_W-1:0] cfg_data = '0;

  bit idle_enable = 1'b1;
  bit hold_off_request = 1'b0;
  int period_settings = 0;

  event_timer_register_block dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Tracks the timer registers and holds the results the block owes us.
  class timer_scoreboard;
    logic [PERIOD_W-1:0] period;
    logic [63:0] main_count;
    bit count_enable;
    bit inten [NUM_T];
    bit periodic [NUM_T];
    logic [4:0] route [NUM_T];
    logic [63:0] compare_value [NUM_T];
    logic [63:0] interval [NUM_T];
    bit second_write [NUM_T];
    out_word_t expected_results [$];
    int errors = 0;
    int items_seen = 0;
    int results_checked = 0;
    int fire_events = 0;

    function new();
      period = PERIOD_RESET;
      main_count = '0;
      count_enable = 1'b0;
      for (int n = 0; n < NUM_T; n++) begin
        inten[n] = 1'b0;
        periodic[n] = 1'b0;
        route[n] = '0;
        compare_value[n] = '1;
        interval[n] = '0;
        second_write[n] = 1'b0;
      end
    endfunction

    function int find_timer(logic [9:0] off, output bit is_cmp);
      int n;
      is_cmp = 1'b0;
      for (n = 0; n < NUM_T; n++) begin
        if (32'(off) == OFF_TIMER_BASE + n * TIMER_STRIDE) return n;
        if (32'(off) == OFF_CMP_BASE + n * TIMER_STRIDE) begin
          is_cmp = 1'b1;
          return n;
        end
      end
      return -1;
    endfunction

    function logic [63:0] read_reg(logic [9:0] off);
      int n;
      bit is_cmp;
      logic [63:0] v;
      if (off == OFF_CAPS) return (64'(period) << 32) | (64'(NUM_T - 1) << 8);
      if (off == OFF_CONFIG) return 64'(count_enable);
      if (off == OFF_COUNTER) return main_count;
      n = find_timer(off, is_cmp);
      if (n < 0) return '0;
      if (is_cmp) return compare_value[n];
      v = '0;
      v[TCFG_PERCAP_BIT] = 1'b1;
      v[TCFG_INTEN_BIT] = inten[n];
      v[TCFG_PERIODIC_BIT] = periodic[n];
      v[TCFG_ROUTE_LSB +: 5] = route[n];
      return v;
    endfunction

    function void write_reg(logic [9:0] off, logic [63:0] d);
      int n;
      bit is_cmp;
      if (off == OFF_CONFIG) begin
        count_enable = d[GCFG_ENABLE_BIT];
        return;
      end
      if (off == OFF_COUNTER) begin
        main_count = d;
        return;
      end
      n = find_timer(off, is_cmp);
      if (n < 0) return;
      if (!is_cmp) begin
        inten[n] = d[TCFG_INTEN_BIT];
        periodic[n] = d[TCFG_PERIODIC_BIT];
        route[n] = d[TCFG_ROUTE_LSB +: 5];
        second_write[n] = 1'b0;
      end else if (periodic[n] && second_write[n]) begin
        interval[n] = d;
        second_write[n] = 1'b0;
      end else begin
        compare_value[n] = d;
        second_write[n] = periodic[n];
      end
    endfunction

    function logic [FIRED_W-1:0] tick();
      logic [FIRED_W-1:0] fired;
      int n;
      fired = '0;
      if (!count_enable) return fired;
      main_count = main_count + 64'd1;
      for (n = 0; n < NUM_T; n++) begin
        if (inten[n] && main_count == compare_value[n]) begin
          fired[n] = 1'b1;
          if (periodic[n]) compare_value[n] = compare_value[n] + interval[n];
        end
      end
      return fired;
    endfunction

    function void note_item(in_word_t w);
      out_word_t r;
      r = '0;
      case (w.command)
        CMD_READ:  r.read_data = read_reg(w.register_offset);
        CMD_WRITE: write_reg(w.register_offset, w.write_data);
        CMD_TICK:  r.timers_fired = tick();
        default: ;
      endcase
      fire_events += $countones(r.timers_fired);
      items_seen++;
      expected_results.push_back(r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word read_data %h timers_fired %b",
                 $time, got.read_data, got.timers_fired);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      results_checked++;
      if (got.read_data !== want.read_data) begin
        $display("%0t: read_data expected %h actual %h", $time, want.read_data, got.read_data);
        errors++;
      end
      if (got.timers_fired !== want.timers_fired) begin
        $display("%0t: timers_fired expected %b actual %b",
                 $time, want.timers_fired, got.timers_fired);
        errors++;
      end
    endfunction
  endclass

  timer_scoreboard sb = new();

  function automatic in_word_t make_word(logic [1:0] cmd, logic [9:0] off, logic [63:0] d);
    in_word_t w;
    w.command = cmd;
    w.register_offset = off;
    w.write_data = d;
    return w;
  endfunction

  function automatic logic [9:0] timer_reg(int n, bit is_cmp);
    return 10'((is_cmp ? OFF_CMP_BASE : OFF_TIMER_BASE) + n * TIMER_STRIDE);
  endfunction

  // Mostly register traffic aimed at live timers, with comparators and the
  // counter placed close to each other so that ticks actually fire.
  function automatic in_word_t random_word();
    in_word_t w;
    int sel;
    int pick;
    int n;
    n = $urandom_range(NUM_T - 1);
    w.write_data = {$urandom, $urandom};
    w.register_offset = 10'($urandom);
    sel = $urandom_range(99);
    if (sel < 45) begin
      w.command = CMD_TICK;
    end else if (sel < 47) begin
      w.command = CMD_UNUSED;
    end else begin
      w.command = (sel < 72) ? CMD_READ : CMD_WRITE;
      pick = $urandom_range(99);
      if (pick < 5) begin
        w.register_offset = OFF_CAPS;
      end else if (pick < 15) begin
        w.register_offset = OFF_CONFIG;
        w.write_data[GCFG_ENABLE_BIT] = ($urandom_range(9) != 0);
      end else if (pick < 25) begin
        w.register_offset = OFF_COUNTER;
        case ($urandom_range(2))
          0: w.write_data = sb.compare_value[n] - 64'($urandom_range(1, 12));
          1: w.write_data = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 10));
          default: ;
        endcase
      end else if (pick < 45) begin
        w.register_offset = timer_reg(n, 1'b0);
        w.write_data[TCFG_INTEN_BIT] = ($urandom_range(4) != 0);
      end else if (pick < 85) begin
        w.register_offset = timer_reg(n, 1'b1);
        if ($urandom_range(7) != 0) begin
          if (sb.periodic[n] && sb.second_write[n])
            w.write_data = 64'($urandom_range(0, 8));
          else
            w.write_data = sb.main_count + 64'($urandom_range(1, 16));
        end
      end
    end
    return w;
  endfunction

  // Entered and left at a falling edge; valid stays high into the next word.
  task automatic send_word(input in_word_t w);
    while (idle_enable && $urandom_range(99) < 32) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    item = w;
    do @(posedge clk); while (!item_ready);
    sb.note_item(w);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    item_valid = 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_tick_period(input logic [PERIOD_W-1:0] p);
    cfg_valid = 1'b1;
    cfg_data = p;
    do @(posedge clk); while (!cfg_ready);
    sb.period = p;
    period_settings++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        result_ready = 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
      end
      result_ready = !idle_enable || ($urandom_range(99) >= 32);
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [PERIOD_W-1:0] period_list [RAND_PHASES];
    period_list[0] = PERIOD_MIN;
    period_list[1] = PERIOD_MAX;
    period_list[2] = 27'($urandom_range(1, 100000000));
    period_list[3] = PERIOD_RESET;
    period_list[4] = 27'($urandom_range(2, 1000));
    period_list[5] = 27'($urandom_range(1, 100000000));
    period_list[6] = PERIOD_MAX;
    period_list[7] = PERIOD_MIN;

    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Reset values, unknown and unaligned offsets, a timer beyond the last one.
    send_word(make_word(CMD_READ, OFF_CAPS, '0));
    send_word(make_word(CMD_READ, OFF_CONFIG, '0));
    send_word(make_word(CMD_READ, OFF_COUNTER, '0));
    send_word(make_word(CMD_READ, timer_reg(0, 1'b0), '0));
    send_word(make_word(CMD_READ, timer_reg(0, 1'b1), '0));
    send_word(make_word(CMD_READ, 10'h3FF, '1));
    send_word(make_word(CMD_READ, 10'h104, '0));
    send_word(make_word(CMD_WRITE, timer_reg(NUM_T, 1'b0), '1));
    send_word(make_word(CMD_READ, timer_reg(NUM_T, 1'b0), '0));
    send_word(make_word(CMD_WRITE, OFF_CAPS, '1));
    send_word(make_word(CMD_READ, OFF_CAPS, '0));
    send_word(make_word(CMD_TICK, 10'h000, '0));
    // Periodic timer with a zero interval fires at the last count before the wrap,
    // then a one-shot timer fires just after the wrap.
    send_word(make_word(CMD_WRITE, OFF_CONFIG, '1));
    send_word(make_word(CMD_WRITE, OFF_COUNTER, 64'hFFFF_FFFF_FFFF_FFFD));
    send_word(make_word(CMD_WRITE, timer_reg(0, 1'b0), '1));
    send_word(make_word(CMD_READ, timer_reg(0, 1'b0), '0));
    send_word(make_word(CMD_WRITE, timer_reg(0, 1'b1), '1));
    send_word(make_word(CMD_WRITE, timer_reg(0, 1'b1), '0));
    send_word(make_word(CMD_WRITE, timer_reg(1, 1'b0), 64'(1) << TCFG_INTEN_BIT));
    send_word(make_word(CMD_WRITE, timer_reg(1, 1'b1), 64'd1));
    repeat (4) send_word(make_word(CMD_TICK, 10'h3FF, '1));
    send_word(make_word(CMD_UNUSED, OFF_COUNTER, '1));
    send_word(make_word(CMD_READ, OFF_COUNTER, '0));

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_for_results();
      write_tick_period(period_list[ph]);
      idle_enable = (ph != 3);
      if (ph == 5) hold_off_request = 1'b1;
      send_word(make_word(CMD_READ, OFF_CAPS, '0));
      repeat (PHASE_ITEMS) send_word(random_word());
    end
    idle_enable = 1'b1;
    wait_for_results();

    $display("Checked %0d items under %0d tick period settings, with idle-free and",
             sb.items_seen, period_settings);
    $display("back-pressure phases; timers fired %0d times.", sb.fire_events);
    if (sb.errors == 0 && sb.expected_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/etr_pkg.sv
rtl/etr_timer.sv
rtl/event_timer_register_block.sv
test/event_timer_register_block_tb.sv
